// File: design/tkps_pkg.sv
// Package: shared types and constants for the top-k probability select unit.
package tkps_pkg;

  localparam int MAX_TOP    = 5;
  localparam int PROB_W     = 17;
  localparam int POS_W      = 18;
  localparam int SUM_W      = 24;
  localparam int TOPC_W     = 3;
  localparam int PADDR_W    = 3;

  localparam logic [PROB_W-1:0] PROB_ONE  = 17'd65536;
  localparam logic [SUM_W-1:0]  SUM_MAX   = 24'hFFFFFF;
  localparam logic [SUM_W-1:0]  SUM_TWO   = 24'd131072;
  localparam logic [POS_W-1:0]  POS_MAX   = 18'h3FFFF;
  localparam logic [TOPC_W-1:0] TOPC_MAX  = 3'd5;
  localparam logic [TOPC_W-1:0] TOPC_RST  = 3'd5;

  // register index, taken from paddr[2]
  localparam logic REG_TOP_COUNT = 1'b0;

  typedef struct packed {
    logic              valid;
    logic [POS_W-1:0]  pos;
    logic [PROB_W-1:0] prob;
  } slot_t;

  // list update result handed to the output buffer
  typedef struct packed {
    logic emit;
    logic done;
  } list_stat_t;

endpackage

// File: design/top_k_probability_select_unit.sv
// Top level: top-k probability select unit with APB config and result buffer.
//
//  channel | direction | beat contents
//  --------+-----------+---------------------------------------------------
//  in_     | input     | prob_value (Q1.16), last_in_distribution
//  out_    | output    | rank, token_position, kept_prob, slot_filled,
//          |           | last_result
//  apb     | config    | top_count at byte address 0
//
// Each input beat is folded into the ranked list in the cycle it is accepted
// (one comparator per slot, one saturating add), so in_ready stays high
// every cycle while no list is waiting. An emitted list of k entries is
// captured in a snapshot buffer and drained one beat per ready cycle;
// the next emitting beat may enter on the cycle the final entry leaves, and
// beats after an early stop pass at full rate even while the buffer drains.
// Reset is synchronous: empty list, sums and counts zero, top_count 5.
module top_k_probability_select_unit import tkps_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // input beats
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [PROB_W-1:0]  in_prob_value,
  input  logic               in_last_in_distribution,
  // result beats
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_rank,
  output logic [POS_W-1:0]   out_token_position,
  output logic [PROB_W-1:0]  out_kept_prob,
  output logic               out_slot_filled,
  output logic               out_last_result,
  // config
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [TOPC_W-1:0] top_count_r;
  logic [TOPC_W-1:0] k_eff;
  logic              cfg_wr;

  logic              in_fire, out_fire, last_beat;
  list_stat_t        stat;
  slot_t             snap   [MAX_TOP];
  slot_t             snap_r [MAX_TOP];
  logic              busy_r, busy_nxt;
  logic [2:0]        idx_r, idx_nxt;
  logic [TOPC_W-1:0] k_r, k_nxt;
  slot_t             cur;

  // ---- config register ----
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_TOP_COUNT) ? {29'd0, top_count_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_count_r <= TOPC_RST;
    end else if (cfg_wr && paddr[2] == REG_TOP_COUNT) begin
      top_count_r <= pwdata[TOPC_W-1:0];
    end
  end

  // values above five clamp to five
  assign k_eff = (top_count_r > TOPC_MAX) ? TOPC_MAX : top_count_r;

  // ---- handshake ----
  assign last_beat = (idx_r == k_r - 3'd1);
  assign out_fire  = out_valid && out_ready;
  // after an early stop no beat can emit, so those beats pass at full rate
  assign in_ready  = !busy_r || stat.done || (out_ready && last_beat);
  assign in_fire   = in_valid && in_ready;

  tkps_list u_list (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_fire),
    .prob_in (in_prob_value),
    .last_in (in_last_in_distribution),
    .k_eff   (k_eff),
    .stat    (stat),
    .snap    (snap)
  );

  // ---- snapshot buffer and drain counter ----
  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    k_nxt    = k_r;
    if (out_fire) begin
      if (last_beat) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 3'd1;
      end
    end
    if (stat.emit) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
      k_nxt    = k_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
      k_r    <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      k_r    <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.emit) begin
      snap_r <= snap;
    end
  end

  // ---- result fields ----
  assign cur                = snap_r[idx_r];
  assign out_valid          = busy_r;
  assign out_rank           = idx_r;
  assign out_token_position = cur.valid ? cur.pos : '0;
  assign out_kept_prob      = cur.valid ? cur.prob : '0;
  assign out_slot_filled    = cur.valid;
  assign out_last_result    = last_beat;

`ifndef SYNTHESIS
  // a new list never lands on one that is still draining
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    stat.emit |-> (!busy_r || (out_ready && last_beat)))
    else $error("list emitted over an undrained buffer");

  // rank stays below the captured count
  a_rank_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (idx_r < k_r))
    else $error("rank beyond captured list length");

  // the last beat of a distribution always rearms the list
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_last_in_distribution) |=> !stat.done)
    else $error("early-stop flag survived end of distribution");
`endif

endmodule

// File: design/tkps_list.sv
// Ranked slot list: insertion, running sum, position count and early-stop test.
module tkps_list import tkps_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [PROB_W-1:0] prob_in,
  input  logic              last_in,
  input  logic [TOPC_W-1:0] k_eff,
  output list_stat_t        stat,
  output slot_t             snap [MAX_TOP]
);

  slot_t             slots_r   [MAX_TOP];
  slot_t             slots_nxt [MAX_TOP];
  slot_t             ins_slots [MAX_TOP];
  logic [POS_W-1:0]  pos_cnt_r, pos_cnt_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt, sum_upd;
  logic              fe_r, fe_nxt;

  logic [PROB_W-1:0] v;
  logic [MAX_TOP-1:0] hit, no_hit_ahead;
  logic [SUM_W:0]    sum_add;
  logic [SUM_W:0]    tail_add;
  logic [TOPC_W-1:0] tail_idx;
  slot_t             tail;
  slot_t             new_slot;
  logic              stop;

  always_comb begin
    v = (prob_in > PROB_ONE) ? PROB_ONE : prob_in;
    new_slot.valid = 1'b1;
    new_slot.pos   = pos_cnt_r;
    new_slot.prob  = v;

    // first slot that is empty or smaller takes the value; a tie stays ahead
    for (int i = 0; i < MAX_TOP; i++) begin
      hit[i] = !slots_r[i].valid || (v > slots_r[i].prob);
    end
    no_hit_ahead[0] = 1'b1;
    for (int i = 1; i < MAX_TOP; i++) begin
      no_hit_ahead[i] = no_hit_ahead[i-1] & ~hit[i-1];
    end
    ins_slots[0] = hit[0] ? new_slot : slots_r[0];
    for (int i = 1; i < MAX_TOP; i++) begin
      if (hit[i] && no_hit_ahead[i]) begin
        ins_slots[i] = new_slot;
      end else if (no_hit_ahead[i]) begin
        ins_slots[i] = slots_r[i];
      end else begin
        ins_slots[i] = slots_r[i-1];
      end
    end

    sum_add = {1'b0, sum_r} + (SUM_W+1)'(v);
    sum_upd = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];

    tail_idx = (k_eff == '0) ? '0 : k_eff - 3'd1;
    tail     = ins_slots[tail_idx];
    tail_add = {1'b0, sum_upd} + (SUM_W+1)'(tail.prob);
    if (k_eff == '0) begin
      stop = 1'b0;
    end else if (tail.valid) begin
      stop = tail_add >= (SUM_W+1)'(PROB_ONE);
    end else begin
      stop = sum_upd >= SUM_TWO;
    end

    stat.emit = accept && !fe_r && (k_eff != '0) && (stop || last_in);
    stat.done = fe_r;
    snap      = ins_slots;

    slots_nxt   = slots_r;
    sum_nxt     = sum_r;
    pos_cnt_nxt = pos_cnt_r;
    fe_nxt      = fe_r;
    if (accept) begin
      if (last_in) begin
        for (int i = 0; i < MAX_TOP; i++) begin
          slots_nxt[i] = '0;
        end
        sum_nxt     = '0;
        pos_cnt_nxt = '0;
        fe_nxt      = 1'b0;
      end else if (!fe_r) begin
        slots_nxt   = ins_slots;
        sum_nxt     = sum_upd;
        pos_cnt_nxt = (pos_cnt_r == POS_MAX) ? pos_cnt_r : pos_cnt_r + 18'd1;
        fe_nxt      = stop;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_TOP; i++) begin
        slots_r[i] <= '0;
      end
      sum_r     <= '0;
      pos_cnt_r <= '0;
      fe_r      <= 1'b0;
    end else begin
      slots_r   <= slots_nxt;
      sum_r     <= sum_nxt;
      pos_cnt_r <= pos_cnt_nxt;
      fe_r      <= fe_nxt;
    end
  end

endmodule
